>>> hdl/mtft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel tour package
// Widths, register map, item codes and shared types for the channel
// move-to-front list with automatic tour.
// ----------------------------------------------------------------------------
package mtft_pkg;

  localparam int CHAN_W       = 4;
  localparam int ORDER_W      = 32;
  localparam int ORDER_SLOTS  = ORDER_W / CHAN_W;
  localparam int TICK_W       = 16;
  localparam int DEF_CHANNELS = 8;

  localparam logic [TICK_W-1:0] PERIOD_RESET = TICK_W'(1000);

  // Item codes.
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_TOUR_ENABLE = 1'b0;
  localparam logic REG_TOUR_PERIOD = 1'b1;

  // Request handed to the move-to-front list.
  typedef struct packed {
    logic              valid;
    logic [CHAN_W-1:0] channel;
  } sel_req_t;

endpackage

>>> hdl/mtft_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel tour stream interfaces
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface mtft_item_if import mtft_pkg::*;;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAN_W-1:0] channel;

  modport source (output valid, output mode, output channel, input ready);
  modport sink   (input valid, input mode, input channel, output ready);
endinterface

interface mtft_result_if import mtft_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CHAN_W-1:0]  current_channel;
  logic [ORDER_W-1:0] order;
  logic               layout_pulse;

  modport source (output valid, output current_channel, output order,
                  output layout_pulse, input ready);
  modport sink   (input valid, input current_channel, input order,
                  input layout_pulse, output ready);
endinterface

>>> hdl/mtft_mtf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front list update
// Finds the requested channel in the list and moves it to the front slot,
// the slots ahead of it shifting back by one, all in parallel.
// ----------------------------------------------------------------------------
module mtft_mtf import mtft_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  sel_req_t          req,
  input  logic [CHAN_W-1:0] slots_in  [CHANNELS],
  output logic [CHAN_W-1:0] slots_out [CHANNELS],
  output logic              hit
);

  logic [CHANNELS-1:0] shift;
  logic                seen;
  logic                in_range;

  always_comb begin
    in_range = req.valid && (req.channel != '0) &&
               (req.channel <= CHAN_W'(CHANNELS));
    seen = 1'b0;
    // A slot shifts when no earlier slot holds the channel.
    for (int i = 0; i < CHANNELS; i++) begin
      shift[i] = !seen;
      seen     = seen | (slots_in[i] == req.channel);
    end
    hit = in_range && seen;
    slots_out[0] = hit ? req.channel : slots_in[0];
    for (int i = 1; i < CHANNELS; i++) begin
      slots_out[i] = (hit && shift[i]) ? slots_in[i-1] : slots_in[i];
    end
  end

endmodule

>>> hdl/channel_move_to_front_tour.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel move-to-front list with automatic tour
// Keeps the display channels in priority order, moves a selected channel to
// the front and, on ticks with touring enabled, steps through the channels.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Protocol     Payload
//  -------   ---   ----------   ------------------------------------------
//  item      in    valid/ready  mode, channel
//  result    out   valid/ready  current_channel, order, layout_pulse
//  APB       in    APB write    tour_enable (0x0), tour_period_ticks (0x4)
//
// Each item passes from transfer to result through the input stage register
// and then the list update into the result register. Unless the result
// stalls, one item is taken every cycle; the list, tour and tick state is
// written in the same cycle as the result, so the next item sees it at once.
// A stalled result holds the input stage, which in turn lowers item.ready.
// The synchronous reset restores the list to channel order 1..CHANNELS with
// channel 1 selected, the tour at position 0 and the tick count at zero.
//
module channel_move_to_front_tour import mtft_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                clk,
  input  logic                rst,
  mtft_item_if.sink           item,
  mtft_result_if.source       result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // Only the first slots that fit in the packed order word are reported.
  localparam int PACK_SLOTS = (CHANNELS < ORDER_SLOTS) ? CHANNELS : ORDER_SLOTS;

  // Configuration registers.
  logic              tour_enable;
  logic [TICK_W-1:0] tour_period;

  // Input stage.
  logic              stage_valid;
  logic              stage_mode;
  logic [CHAN_W-1:0] stage_channel;
  logic              stage_go;

  // List and tour state.
  logic [CHAN_W-1:0] slots       [CHANNELS];
  logic [CHAN_W-1:0] slots_next  [CHANNELS];
  logic [CHAN_W-1:0] selected_channel;
  logic [CHAN_W-1:0] tour_position;
  logic [TICK_W-1:0] tick_count;

  // Result register.
  logic               out_valid;
  logic [CHAN_W-1:0]  out_channel;
  logic [ORDER_W-1:0] out_order;
  logic               out_changed;

  // Update logic.
  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] period_eff;
  logic              tour_step;
  logic [CHAN_W:0]   tour_sum;
  logic [CHAN_W-1:0] tour_next;
  sel_req_t          req;
  logic              hit;
  logic [ORDER_W-1:0] order_next;

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; reads return the
  // register addressed by the word index.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tour_enable <= 1'b0;
      tour_period <= PERIOD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_TOUR_ENABLE: tour_enable <= pwdata[0];
        REG_TOUR_PERIOD: tour_period <= pwdata[TICK_W-1:0];
        default:         tour_enable <= tour_enable;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TOUR_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, tour_enable};
      REG_TOUR_PERIOD: prdata = {{(PDATA_W-TICK_W){1'b0}}, tour_period};
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input stage. It moves on whenever the result register is free or is
  // being emptied in this cycle, so a new transfer can land every cycle.
  // --------------------------------------------------------------------------
  assign stage_go   = stage_valid && (!out_valid || result.ready);
  assign item.ready = !stage_valid || stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage_mode    <= item.mode;
      stage_channel <= item.channel;
    end
  end

  // --------------------------------------------------------------------------
  // Tour timing. The count wraps at 16 bits, a zero period behaves as one,
  // and greater-or-equal lets a lowered period take effect on the next tick.
  // --------------------------------------------------------------------------
  always_comb begin
    tick_inc   = tick_count + TICK_W'(1);
    period_eff = (tour_period == '0) ? TICK_W'(1) : tour_period;
    tour_step  = (stage_mode == MODE_TICK) && tour_enable && (tick_inc >= period_eff);
    tour_sum   = {1'b0, tour_position} + (CHAN_W+1)'(1);
    tour_next  = (tour_sum > (CHAN_W+1)'(CHANNELS)) ? CHAN_W'(1) : tour_sum[CHAN_W-1:0];

    // A select item names its channel; a tour step selects the next stop.
    if (stage_mode == MODE_SELECT) begin
      req.valid   = 1'b1;
      req.channel = stage_channel;
    end else begin
      req.valid   = tour_step;
      req.channel = tour_next;
    end
  end

  mtft_mtf #(
    .CHANNELS (CHANNELS)
  ) u_mtf (
    .req       (req),
    .slots_in  (slots),
    .slots_out (slots_next),
    .hit       (hit)
  );

  always_comb begin
    order_next = '0;
    for (int i = 0; i < PACK_SLOTS; i++) begin
      order_next[i*CHAN_W +: CHAN_W] = slots_next[i];
    end
  end

  // --------------------------------------------------------------------------
  // State update, written together with the result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        slots[i] <= CHAN_W'(i + 1);
      end
      selected_channel <= CHAN_W'(1);
      tour_position    <= '0;
      tick_count       <= '0;
    end else if (stage_go) begin
      slots <= slots_next;
      if (hit) begin
        selected_channel <= req.channel;
      end
      // A manual select leaves the tour untouched.
      if (stage_mode == MODE_TICK && tour_enable) begin
        if (tour_step) begin
          tick_count    <= '0;
          tour_position <= tour_next;
        end else begin
          tick_count <= tick_inc;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go) begin
      out_channel <= hit ? req.channel : selected_channel;
      out_order   <= order_next;
      out_changed <= hit;
    end
  end

  assign result.valid           = out_valid;
  assign result.current_channel = out_channel;
  assign result.order           = out_order;
  assign result.layout_pulse    = out_changed;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_front_is_selected: assert property (@(posedge clk) disable iff (rst)
    slots[0] == selected_channel)
    else $error("front slot differs from the selected channel");

  a_selected_range: assert property (@(posedge clk) disable iff (rst)
    (selected_channel != '0) && (selected_channel <= CHAN_W'(CHANNELS)))
    else $error("selected channel out of range");

  a_tour_range: assert property (@(posedge clk) disable iff (rst)
    tour_position <= CHAN_W'(CHANNELS))
    else $error("tour position out of range");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    stage_valid && out_valid && !result.ready |=> stage_valid)
    else $error("input stage lost an item while the result stalled");

  a_tour_step_changes: assert property (@(posedge clk) disable iff (rst)
    stage_go && tour_step |-> hit)
    else $error("tour step did not select a channel");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel tour testbench
// Drives select and tick items into the move-to-front channel list. Every
// result is checked field by field, against a hand-typed value or against
// an independent model of the list, the tour position and the tick count.
// The run starts with a short table of hand-picked items and then moves
// to random phases under varied tour settings.
// ----------------------------------------------------------------------------
module testbench import mtft_pkg::*;;

  localparam int N_CH        = DEF_CHANNELS;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 104;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;

  // One result as the display logic sees it.
  typedef struct packed {
    logic [CHAN_W-1:0]  cur;
    logic [ORDER_W-1:0] order;
    logic               changed;
  } view_t;

  // Kinds of row in the directed table. A known row carries its result
  // typed in by hand; a plain row leaves the result to the model.
  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_KNOWN,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              mode;
    logic [CHAN_W-1:0] chan;
    logic              reg_idx;
    logic [15:0]       wdata;
    view_t             want;
  } plan_row_t;

  localparam int PLAN_ROWS = 32;

  // The directed table. The first rows start from the reset order 1..8 and
  // cover invalid selects (zero, just above the last channel, all ones), a
  // select of the channel already at the front and one of the channel in
  // the last slot. Ticks with touring off must leave everything alone.
  // With touring on, a zero period advances on every tick and nine ticks
  // wrap the tour past the last channel. The period is then raised to its
  // largest value and lowered below the count already reached, and touring
  // is switched off and on again to show that the count is held.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_KNOWN, MODE_TICK,   4'd0,  REG_TOUR_ENABLE, 16'd0,
      '{4'd1, 32'h87654321, 1'b0}},
    '{ROW_KNOWN, MODE_SELECT, 4'd0,  REG_TOUR_ENABLE, 16'd0,
      '{4'd1, 32'h87654321, 1'b0}},
    '{ROW_KNOWN, MODE_SELECT, 4'd15, REG_TOUR_ENABLE, 16'd0,
      '{4'd1, 32'h87654321, 1'b0}},
    '{ROW_KNOWN, MODE_SELECT, 4'd9,  REG_TOUR_ENABLE, 16'd0,
      '{4'd1, 32'h87654321, 1'b0}},
    '{ROW_KNOWN, MODE_SELECT, 4'd1,  REG_TOUR_ENABLE, 16'd0,
      '{4'd1, 32'h87654321, 1'b1}},
    '{ROW_KNOWN, MODE_SELECT, 4'd8,  REG_TOUR_ENABLE, 16'd0,
      '{4'd8, 32'h76543218, 1'b1}},
    '{ROW_KNOWN, MODE_TICK,   4'd15, REG_TOUR_ENABLE, 16'd0,
      '{4'd8, 32'h76543218, 1'b0}},
    '{ROW_ITEM,  MODE_SELECT, 4'd4,  REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_ITEM,  MODE_SELECT, 4'd2,  REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_WRITE, MODE_TICK,   4'd0,  REG_TOUR_ENABLE, 16'd1, '0},
    '{ROW_WRITE, MODE_TICK,   4'd0,  REG_TOUR_PERIOD, 16'd0, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd0,  REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd1,  REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd2,  REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd4,  REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd8,  REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd15, REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd10, REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd5,  REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd3,  REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_WRITE, MODE_TICK,   4'd0,  REG_TOUR_PERIOD, 16'hFFFF, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd7,  REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd11, REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd12, REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_WRITE, MODE_TICK,   4'd0,  REG_TOUR_PERIOD, 16'd2, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd13, REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd14, REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_WRITE, MODE_TICK,   4'd0,  REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd6,  REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_WRITE, MODE_TICK,   4'd0,  REG_TOUR_ENABLE, 16'd1, '0},
    '{ROW_ITEM,  MODE_TICK,   4'd9,  REG_TOUR_ENABLE, 16'd0, '0},
    '{ROW_ITEM,  MODE_SELECT, 4'd3,  REG_TOUR_ENABLE, 16'd0, '0}
  };

  logic clk;
  logic rst;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  mtft_item_if   item_bus ();
  mtft_result_if view_bus ();

  channel_move_to_front_tour #(.CHANNELS(N_CH)) DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (item_bus),
    .result  (view_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Model of the list, the tour and the tick counter, together with its
  // own copy of the two registers.
  logic [CHAN_W-1:0] model_slots [N_CH];
  logic [CHAN_W-1:0] model_current;
  logic [CHAN_W-1:0] model_tour_pos;
  logic [TICK_W-1:0] model_ticks;
  logic              model_tour_on;
  logic [TICK_W-1:0] model_period;

  // Results still owed by the block, oldest first.
  view_t pending_views [$];

  int  fault_count;
  int  views_seen;
  int  cycle_count;
  bit  send_idle;
  bit  recv_idle;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung block must not keep the run going for ever.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Gap lengths for both sides: mostly none or short, now and then long.
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return 0;
    else if (roll < 85)
      return $urandom_range(1, 3);
    else if (roll < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Moves a channel to the front slot, shifting the slots ahead of its old
  // place back by one. Returns 1 when the select took effect.
  function automatic logic bring_forward(input logic [CHAN_W-1:0] ch);
    int hit;
    hit = -1;
    if (ch < 1 || ch > N_CH)
      return 1'b0;
    for (int i = 0; i < N_CH; i++)
      if (hit < 0 && model_slots[i] == ch)
        hit = i;
    if (hit < 0)
      return 1'b0;
    for (int i = hit; i > 0; i--)
      model_slots[i] = model_slots[i-1];
    model_slots[0] = ch;
    model_current  = ch;
    return 1'b1;
  endfunction

  // Applies one accepted item to the model and returns the result it
  // should produce.
  function automatic view_t advance_display(input logic mode,
                                            input logic [CHAN_W-1:0] ch);
    view_t view;
    int    limit;
    int    nxt;
    view = '0;
    if (mode == MODE_SELECT) begin
      view.changed = bring_forward(ch);
    end else if (model_tour_on) begin
      // A zero period behaves as one, and the greater-or-equal compare lets a
      // lowered period catch up on the very next tick.
      limit = (model_period == '0) ? 1 : int'(model_period);
      model_ticks = model_ticks + 1'b1;
      if (int'(model_ticks) >= limit) begin
        model_ticks = '0;
        nxt = int'(model_tour_pos) + 1;
        if (nxt > N_CH)
          nxt = 1;
        model_tour_pos = CHAN_W'(nxt);
        view.changed   = bring_forward(CHAN_W'(nxt));
      end
    end
    view.cur = model_current;
    for (int i = 0; i < N_CH && i < ORDER_SLOTS; i++)
      view.order[CHAN_W*i +: CHAN_W] = model_slots[i];
    return view;
  endfunction

  // Offers one item, waits for its transfer and records what it should
  // produce. Valid is only lowered when a gap is wanted, so a back-to-back
  // item never sees valid dropped and raised in the same step.
  task automatic offer_item(input logic mode, input logic [CHAN_W-1:0] ch,
                            input bit known, input view_t want);
    view_t calc;
    int    gap;
    gap = send_idle ? idle_gap() : 0;
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid   <= 1'b1;
    item_bus.mode    <= mode;
    item_bus.channel <= ch;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    calc = advance_display(mode, ch);
    pending_views = {pending_views, (known ? want : calc)};
  endtask

  // Stops offering items and waits until every owed result has been taken.
  // Every item yields a result, so nothing is left inside the block then.
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  // APB write: a setup phase, then an access phase that ends at the edge
  // where pready is seen high, then the port rests idle before anything else
  // drives the port. The bits above the register's width carry random
  // junk, which the block must ignore.
  task automatic write_reg(input logic idx, input logic [15:0] value);
    logic [PDATA_W-1:0] word;
    if (idx == REG_TOUR_ENABLE) begin
      word = {$urandom()} << 1;
      word[0] = value[0];
    end else begin
      word = {$urandom()} << TICK_W;
      word[TICK_W-1:0] = value;
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_TOUR_ENABLE)
      model_tour_on = word[0];
    else
      model_period = word[TICK_W-1:0];
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    fault_count++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endtask

  // Result side. Ready is driven in runs and stalls of random length, and
  // once, part-way through the random phases, it is held low for a long
  // stretch while the item side keeps offering, so that both stages of the
  // block fill up and item.ready has to fall. Every transfer is compared
  // with the oldest owed result.
  initial begin
    int    stall_left;
    int    run_left;
    bit    held_once;
    view_t want;
    stall_left = 0;
    run_left   = 0;
    held_once  = 1'b0;
    view_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && view_bus.valid && view_bus.ready) begin
        views_seen++;
        if (pending_views.size() == 0) begin
          fault_count++;
          $display("%0t: result transfer with nothing owed, got %h %h %b", $time,
                   view_bus.current_channel, view_bus.order,
                   view_bus.layout_pulse);
        end else begin
          want = pending_views.pop_front();
          if (view_bus.current_channel !== want.cur)
            report_mismatch("current_channel", 32'(want.cur),
                            32'(view_bus.current_channel));
          if (view_bus.order !== want.order)
            report_mismatch("order", want.order, view_bus.order);
          if (view_bus.layout_pulse !== want.changed)
            report_mismatch("layout_pulse", 32'(want.changed),
                            32'(view_bus.layout_pulse));
        end
        if (!held_once && views_seen == HOLD_AT) begin
          held_once  = 1'b1;
          stall_left = HOLD_CYCLES;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        view_bus.ready <= 1'b0;
      end else begin
        view_bus.ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else if (recv_idle) begin
          run_left   = $urandom_range(0, 30);
          stall_left = idle_gap();
        end
      end
    end
  end

  // Item side: reset, the directed table and the random phases, then the
  // final verdict.
  initial begin
    plan_row_t   row;
    logic        tour_on;
    logic [15:0] period;
    int          pick;

    fault_count = 0;
    views_seen  = 0;
    send_idle   = 1'b1;
    recv_idle   = 1'b1;

    for (int i = 0; i < N_CH; i++)
      model_slots[i] = CHAN_W'(i + 1);
    model_current  = CHAN_W'(1);
    model_tour_pos = '0;
    model_ticks    = '0;
    model_tour_on  = 1'b0;
    model_period   = PERIOD_RESET;

    rst              <= 1'b1;
    item_bus.valid   <= 1'b0;
    item_bus.mode    <= MODE_TICK;
    item_bus.channel <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Register writes wait until the block has gone quiet.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      row = PLAN[r];
      case (row.kind)
        ROW_WRITE: begin
          drain_results();
          write_reg(row.reg_idx, row.wdata);
        end
        ROW_KNOWN: offer_item(row.mode, row.chan, 1'b1, row.want);
        default:   offer_item(row.mode, row.chan, 1'b0, '0);
      endcase
    end

    // Random phases. The first three pin down a period of one, touring off
    // and a zero period; later ones draw mostly short periods so that the
    // tour moves often, with now and then the largest period or any value.
    // Each phase starts with the item side paused until every owed result
    // has come back.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          tour_on = 1'b1;
          period  = 16'd1;
        end
        1: begin
          tour_on = 1'b0;
          period  = 16'($urandom_range(1, 8));
        end
        2: begin
          tour_on = 1'b1;
          period  = 16'd0;
        end
        default: begin
          tour_on = ($urandom_range(0, 4) != 0);
          case ($urandom_range(0, 9))
            0:          period = 16'd0;
            1, 2, 3, 4,
            5:          period = 16'($urandom_range(1, 6));
            6, 7:       period = 16'($urandom_range(7, 40));
            8:          period = 16'hFFFF;
            default:    period = 16'($urandom_range(1, 65535));
          endcase
        end
      endcase
      drain_results();
      if ($urandom_range(0, 1)) begin
        write_reg(REG_TOUR_PERIOD, period);
        write_reg(REG_TOUR_ENABLE, {15'd0, tour_on});
      end else begin
        write_reg(REG_TOUR_ENABLE, {15'd0, tour_on});
        write_reg(REG_TOUR_PERIOD, period);
      end
      // Some phases run with no gaps at all on the item side.
      send_idle = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)
          offer_item(MODE_TICK, CHAN_W'($urandom_range(0, 15)), 1'b0, '0);
        else if (pick < 90)
          offer_item(MODE_SELECT, CHAN_W'($urandom_range(1, N_CH)), 1'b0, '0);
        else
          offer_item(MODE_SELECT, CHAN_W'($urandom_range(0, 15)), 1'b0, '0);
      end
    end

    // Wind down: let every owed result arrive, then watch a little longer
    // for any stray transfer.
    drain_results();
    repeat (16) @(posedge clk);
    if (fault_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
